// ===== rtl/lru_page_replacement_core_assert.svh =====
// assertion macros shared by the lru page replacement rtl
// no dependencies; include after the module ports are declared
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRU_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, checked outside reset
`define LRU_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/lru_pr_pkg.sv =====
// shared types and fixed widths for the lru page replacement block
// no dependencies
package lru_pr_pkg;

    localparam int TS_W       = 32;  // timestamp and counter width
    localparam int PORT_PAGE_W = 16; // page width on the ports
    localparam int OUT_IDX_W  = 4;   // frame_index port width
    localparam int CFG_W      = 5;   // frames_in_use register width
    localparam int WIDE_IDX_W = 7;   // holds any frame count up to 127

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic en;     // read data for one frame is present
        logic first;  // that frame is frame zero
    } lru_pr_ctl_t;

endpackage

// ===== rtl/lru_pr_unit.sv =====
// shared compare unit: one tag equality and one timestamp compare per cycle while ctl.en is high
// depends on lru_pr_pkg
module lru_pr_unit
    import lru_pr_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int TAG_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lru_pr_ctl_t       ctl,
    input  logic [TAG_W-1:0]  page,
    input  logic              frame_vld,
    input  logic [TAG_W-1:0]  tag,
    input  logic [TS_W-1:0]   use_val,
    input  logic [IDX_W-1:0]  idx,
    output logic              found,
    output logic [IDX_W-1:0]  hit_slot,
    output logic [IDX_W-1:0]  min_slot,
    output logic              min_vld,
    output logic [TAG_W-1:0]  min_tag
);

    logic              found_reg;
    logic [IDX_W-1:0]  hit_slot_reg;
    logic [IDX_W-1:0]  min_slot_reg;
    logic              min_vld_reg;
    logic [TAG_W-1:0]  min_tag_reg;
    logic [TS_W-1:0]   min_use_reg;

    logic              eq;
    logic              lt;
    logic [TS_W-1:0]   use_eff;

    // empty frames count as timestamp zero
    assign eq      = frame_vld && (tag == page);
    assign use_eff = frame_vld ? use_val : '0;
    assign lt      = use_eff < min_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            if (ctl.first)
            begin
                found_reg <= eq;
            end
            else if (eq)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.first)
            begin
                hit_slot_reg <= idx;
                min_slot_reg <= idx;
                min_use_reg  <= use_eff;
                min_vld_reg  <= frame_vld;
                min_tag_reg  <= tag;
            end
            else
            begin
                // keep the lowest-indexed match
                if (eq && !found_reg)
                begin
                    hit_slot_reg <= idx;
                end
                // strict less-than keeps the lowest index on ties
                if (lt)
                begin
                    min_slot_reg <= idx;
                    min_use_reg  <= use_eff;
                    min_vld_reg  <= frame_vld;
                    min_tag_reg  <= tag;
                end
            end
        end
    end

    assign found    = found_reg;
    assign hit_slot = hit_slot_reg;
    assign min_slot = min_slot_reg;
    assign min_vld  = min_vld_reg;
    assign min_tag  = min_tag_reg;

endmodule

// ===== rtl/lru_page_replacement_core.sv =====
// lru page replacement with per-frame timestamps: sequencer, frame table, counters
// depends on lru_pr_pkg, lru_pr_unit and lru_page_replacement_core_assert.svh
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | in        | in_valid / in_stall  | page
//   out     | out       | out_valid / out_stall| hit, frame_index, evicted_valid,
//           |           |                     | evicted_page, fault_count
//   cfg     | in        | cfg_wr_en           | cfg_wr_data (frames_in_use)
//
// a result is valid once its request is accepted, every active frame has been scanned
// and the update is done: one table read and one compare per frame, then an update.
// the next request can be accepted once the block is back in idle after the update.
// the frame table is a single-read-port memory scanned by one compare unit.
// in_stall is high from acceptance until the update is done; the update waits
// while a previous result is still stalled in the output register.
// reset empties all frames and clears both counters; frames_in_use resets to 16.
module lru_page_replacement_core
    import lru_pr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PORT_PAGE_W-1:0] page,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [OUT_IDX_W-1:0]   frame_index,
    output logic                   evicted_valid,
    output logic [PORT_PAGE_W-1:0] evicted_page,
    output logic [TS_W-1:0]        fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [WIDE_IDX_W-1:0] FRAMES_C = WIDE_IDX_W'(FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CFG_W-1:0]       fiu_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [TS_W-1:0]        refcnt_reg, refcnt_next;
    logic [TS_W-1:0]        faults_reg, faults_next;
    logic [IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   chk_vld_reg;
    logic [FRAMES-1:0]      valid_reg;

    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [OUT_IDX_W-1:0]   frame_index_reg;
    logic                   ev_valid_reg;
    logic [PORT_PAGE_W-1:0] ev_page_reg;
    logic [TS_W-1:0]        fault_count_reg;

    logic [PAGE_BITS-1:0]   tag_mem [FRAMES];
    logic [TS_W-1:0]        use_mem [FRAMES];
    logic [PAGE_BITS-1:0]   rd_tag_reg;
    logic [TS_W-1:0]        rd_use_reg;

    logic                   in_acc;
    logic                   out_free;
    logic                   upd_go;
    logic [WIDE_IDX_W-1:0]  fiu_wide;
    logic [WIDE_IDX_W-1:0]  active_wide;
    logic [WIDE_IDX_W-1:0]  last_wide;
    logic [IDX_W-1:0]       last_idx;
    logic                   scan_done;
    logic [31:0]            page_ext;
    lru_pr_ctl_t            ctl;
    logic                   u_found;
    logic [IDX_W-1:0]       u_hit_slot;
    logic [IDX_W-1:0]       u_min_slot;
    logic                   u_min_vld;
    logic [PAGE_BITS-1:0]   u_min_tag;
    logic [IDX_W-1:0]       slot;
    logic [WIDE_IDX_W-1:0]  slot_wide;
    logic [31:0]            ev_tag_ext;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // frame count zero acts as one, counts above FRAMES act as FRAMES
    assign fiu_wide    = WIDE_IDX_W'(fiu_reg);
    assign active_wide = (fiu_wide == '0) ? WIDE_IDX_W'(1) :
                         (fiu_wide > FRAMES_C) ? FRAMES_C : fiu_wide;
    assign last_wide   = active_wide - WIDE_IDX_W'(1);
    assign last_idx    = last_wide[IDX_W-1:0];

    assign page_ext  = 32'(page);
    assign scan_done = (state_reg == S_SCAN) && chk_vld_reg && (chk_idx_reg == last_idx);
    assign upd_go    = (state_reg == S_UPD) && out_free;

    assign ctl.en    = (state_reg == S_SCAN) && chk_vld_reg;
    assign ctl.first = (chk_idx_reg == '0);

    lru_pr_unit #(
        .IDX_W (IDX_W),
        .TAG_W (PAGE_BITS)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .page      (page_reg),
        .frame_vld (valid_reg[chk_idx_reg]),
        .tag       (rd_tag_reg),
        .use_val   (rd_use_reg),
        .idx       (chk_idx_reg),
        .found     (u_found),
        .hit_slot  (u_hit_slot),
        .min_slot  (u_min_slot),
        .min_vld   (u_min_vld),
        .min_tag   (u_min_tag)
    );

    assign slot       = u_found ? u_hit_slot : u_min_slot;
    assign slot_wide  = WIDE_IDX_W'(slot);
    assign ev_tag_ext = 32'(u_min_tag);

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        refcnt_next    = refcnt_reg;
        faults_next    = faults_reg;
        case (state_reg)
            S_IDLE:
            begin
                issue_idx_next = '0;
                if (in_acc)
                begin
                    state_next = S_SCAN;
                    if (refcnt_reg != '1)
                    begin
                        refcnt_next = refcnt_reg + TS_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                // hold the read address on the last frame once issued
                if (issue_idx_reg != last_idx)
                begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
                if (scan_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (!u_found && (faults_reg != '1))
                    begin
                        faults_next = faults_reg + TS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fiu_reg       <= FRAMES_IN_USE_RST;
            refcnt_reg    <= '0;
            faults_reg    <= '0;
            issue_idx_reg <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            refcnt_reg    <= refcnt_next;
            faults_reg    <= faults_next;
            issue_idx_reg <= issue_idx_next;
            chk_idx_reg   <= issue_idx_reg;
            chk_vld_reg   <= (state_reg == S_SCAN);
            if (cfg_wr_en)
            begin
                fiu_reg <= cfg_wr_data;
            end
            if (upd_go)
            begin
                valid_reg[slot] <= 1'b1;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request page capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            page_reg <= page_ext[PAGE_BITS-1:0];
        end
        if (upd_go)
        begin
            hit_reg         <= u_found;
            frame_index_reg <= slot_wide[OUT_IDX_W-1:0];
            ev_valid_reg    <= !u_found && u_min_vld;
            ev_page_reg     <= (!u_found && u_min_vld) ? ev_tag_ext[PORT_PAGE_W-1:0] : '0;
            fault_count_reg <= faults_next;
        end
    end

    // frame table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            use_mem[slot] <= refcnt_reg;
            if (!u_found)
            begin
                tag_mem[slot] <= page_reg;
            end
        end
        rd_tag_reg <= tag_mem[issue_idx_reg];
        rd_use_reg <= use_mem[issue_idx_reg];
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_count_reg;

`include "lru_page_replacement_core_assert.svh"

    `LRU_ASSERT_NEXT(a_acc_scan, clk, rst_n, in_acc, state_reg == S_SCAN, "accepted request did not start a scan")
    `LRU_ASSERT_NEXT(a_upd_out, clk, rst_n, upd_go, out_valid_reg && (valid_reg[$past(slot)]), "update did not load result and mark frame")
    `LRU_ASSERT_NEXT(a_faults_mono, clk, rst_n, 1'b1, faults_reg >= $past(faults_reg), "fault counter went backward")
    `LRU_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid_reg && hit_reg, !ev_valid_reg && (ev_page_reg == '0), "hit reported an eviction")

endmodule
